// ===== sv/rtt_pkg.sv =====
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared codes, defaults and types for the retransmit timeout table.
// ----------------------------------------------------------------------------
package rtt_pkg;

    localparam int ENTRIES_DEF   = 3;
    localparam int TIME_BITS_DEF = 32;

    // entries that own a writable key register
    localparam int KEY_REGS = 3;
    // results reported per tick at most
    localparam int MAX_OUT  = 3;
    localparam int CNT_W    = 2;

    localparam int KEY_W    = 16;
    localparam int CFG_W    = 3;
    localparam int CFG_DW   = 16;

    localparam logic [CFG_W-1:0] CFG_TIMEOUT = 3'd0;
    localparam logic [CFG_W-1:0] CFG_MAX_RTY = 3'd1;
    localparam logic [CFG_W-1:0] CFG_KEY0    = 3'd2;

    localparam logic [1:0] ACT_REGISTER = 2'd0;
    localparam logic [1:0] ACT_ACK      = 2'd1;
    localparam logic [1:0] ACT_TICK     = 2'd2;
    localparam logic [1:0] ACT_QUERY    = 2'd3;

    localparam logic [2:0] EV_DONE      = 3'd0;
    localparam logic [2:0] EV_RESEND    = 3'd1;
    localparam logic [2:0] EV_EXHAUSTED = 3'd2;
    localparam logic [2:0] EV_QUERY     = 3'd3;
    localparam logic [2:0] EV_NONE      = 3'd4;

    typedef struct packed {
        logic [2:0]       ev;
        logic             matched;
        logic [1:0]       index;
        logic [KEY_W-1:0] key;
        logic [7:0]       retries;
        logic             armed;
    } t_result;

endpackage

// ===== sv/retransmit_timeout_table.sv =====
// ----------------------------------------------------------------------------
// retransmit_timeout_table
// Sequence: after accept the table is scanned, one entry per scan cycle;
//   a load state then registers the first result, each further result is
//   loaded after the previous one is taken, and every result is held until
//   taken. A new item is accepted only once the last result of the previous
//   one is taken; the scan runs through the single entry compare/update unit.
// Reset: control idle, entries disarmed and cleared, registers to defaults.
// ----------------------------------------------------------------------------
module retransmit_timeout_table
    import rtt_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_action,
    input  logic [KEY_W-1:0]  i_command_key,
    input  logic [31:0]       i_now_seconds,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_event_res,
    output logic              o_matched,
    output logic [1:0]        o_entry_index,
    output logic [KEY_W-1:0]  o_entry_key,
    output logic [7:0]        o_retry_count,
    output logic              o_armed,
    output logic              o_last_result
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]           r_state;
    logic [IDX_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     r_optr;
    logic                 r_found;
    logic [1:0]           r_action;
    logic [KEY_W-1:0]     r_cmd_key;
    logic [TIME_BITS-1:0] r_now;

    logic [7:0]           r_timeout;
    logic [7:0]           r_max_retries;
    logic [KEY_W-1:0]     r_key     [ENTRIES];
    logic                 r_armed   [ENTRIES];
    logic [7:0]           r_retries [ENTRIES];
    logic [TIME_BITS-1:0] r_start   [ENTRIES];
    logic                 n_armed   [ENTRIES];
    logic [7:0]           n_retries [ENTRIES];
    logic [TIME_BITS-1:0] n_start   [ENTRIES];

    t_result              r_buf [MAX_OUT];
    t_result              r_out;
    logic                 r_out_last;
    logic                 r_out_valid;

    logic [KEY_W-1:0]     s_key;
    logic                 s_armed;
    logic [7:0]           s_ret;
    logic [TIME_BITS-1:0] s_elapsed;
    logic                 s_expired;
    logic                 s_hit;
    logic                 s_wr;
    t_result              s_res;
    t_result              s_none;

    // shared entry unit: one table entry per scan cycle
    always_comb begin
        s_key     = r_key[r_idx];
        s_armed   = r_armed[r_idx];
        s_ret     = r_retries[r_idx];
        s_elapsed = r_now - r_start[r_idx];
        s_expired = s_armed && (s_elapsed >= TIME_BITS'(r_timeout));
        s_hit     = (s_key == r_cmd_key);
        n_armed   = r_armed;
        n_retries = r_retries;
        n_start   = r_start;
        s_wr      = 1'b0;
        s_res.ev      = EV_DONE;
        s_res.matched = 1'b1;
        s_res.index   = 2'(r_idx);
        s_res.key     = s_key;
        s_res.retries = s_ret;
        s_res.armed   = s_armed;
        if (r_state == ST_SCAN) begin
            unique case (r_action)
                ACT_TICK: begin
                    if (s_expired) begin
                        s_wr = (r_cnt < CNT_W'(MAX_OUT));
                        if (s_ret < r_max_retries) begin
                            n_retries[r_idx] = s_ret + 8'd1;
                            n_start[r_idx]   = r_now;
                            s_res.ev         = EV_RESEND;
                            s_res.retries    = s_ret + 8'd1;
                        end else begin
                            // give up: clear every entry sharing this key
                            for (int j = 0; j < ENTRIES; j++) begin
                                if (r_key[j] == s_key) begin
                                    n_armed[j]   = 1'b0;
                                    n_retries[j] = 8'd0;
                                    n_start[j]   = '0;
                                end
                            end
                            s_res.ev      = EV_EXHAUSTED;
                            s_res.retries = 8'd0;
                            s_res.armed   = 1'b0;
                        end
                    end
                end
                ACT_REGISTER: begin
                    s_wr = s_hit && !r_found;
                    if (s_hit && !s_armed) begin
                        n_armed[r_idx]   = 1'b1;
                        n_retries[r_idx] = 8'd0;
                        n_start[r_idx]   = r_now;
                        s_res.retries    = 8'd0;
                        s_res.armed      = 1'b1;
                    end
                end
                ACT_ACK: begin
                    s_wr = s_hit && !r_found;
                    if (s_hit) begin
                        n_armed[r_idx]   = 1'b0;
                        n_retries[r_idx] = 8'd0;
                        n_start[r_idx]   = '0;
                        s_res.retries    = 8'd0;
                        s_res.armed      = 1'b0;
                    end
                end
                ACT_QUERY: begin
                    s_wr     = s_hit && !r_found;
                    s_res.ev = EV_QUERY;
                end
                default: begin
                    s_wr = 1'b0;
                end
            endcase
        end
    end

    // record used when nothing matched or nothing expired
    always_comb begin
        s_none         = '0;
        s_none.ev      = (r_action == ACT_TICK)  ? EV_NONE  :
                         (r_action == ACT_QUERY) ? EV_QUERY : EV_DONE;
        s_none.matched = 1'b0;
    end

    // configuration and key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= 8'd3;
            r_max_retries <= 8'd3;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_TIMEOUT) begin
                r_timeout <= i_cfg_wdata[7:0];
            end
            if (i_cfg_index == CFG_MAX_RTY) begin
                r_max_retries <= i_cfg_wdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (!i_rst_n) begin
                r_key[i] <= KEY_W'(i + 1);
            end else if (i_cfg_wr_en && (i < KEY_REGS) &&
                         (i_cfg_index == CFG_W'(int'(CFG_KEY0) + i))) begin
                r_key[i] <= i_cfg_wdata;
            end
        end
    end

    // entry table
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (!i_rst_n) begin
                r_armed[i]   <= 1'b0;
                r_retries[i] <= 8'd0;
                r_start[i]   <= '0;
            end else begin
                r_armed[i]   <= n_armed[i];
                r_retries[i] <= n_retries[i];
                r_start[i]   <= n_start[i];
            end
        end
    end

    // result buffer
    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_buf[r_cnt[1:0]] <= s_res;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_optr      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_action  <= i_action;
                        r_cmd_key <= i_command_key;
                        r_now     <= TIME_BITS'(i_now_seconds);
                        r_idx     <= '0;
                        r_cnt     <= '0;
                        r_optr    <= '0;
                        r_found   <= 1'b0;
                        r_state   <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (s_wr) begin
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_found <= 1'b1;
                    end
                    if (r_idx == IDX_W'(ENTRIES - 1)) begin
                        r_state <= ST_LOAD;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_LOAD: begin
                    r_out       <= (r_cnt == '0) ? s_none : r_buf[r_optr[1:0]];
                    r_out_last  <= (r_cnt == '0) || (r_optr + CNT_W'(1) == r_cnt);
                    r_out_valid <= 1'b1;
                    r_state     <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (i_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_optr  <= r_optr + CNT_W'(1);
                            r_state <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_out_valid;
    assign o_event_res   = r_out.ev;
    assign o_matched     = r_out.matched;
    assign o_entry_index = r_out.index;
    assign o_entry_key   = r_out.key;
    assign o_retry_count = r_out.retries;
    assign o_armed       = r_out.armed;
    assign o_last_result = r_out_last;

endmodule

// ===== dv/retransmit_timeout_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// retransmit_timeout_table_tb
// Self-checking bench for the retransmit timeout table. A short directed
// sequence walks arm, re-arm, ack, query, expiry, exhaustion and time wrap,
// then random phases with new register settings mix well-formed arm/tick
// traffic with noise while both handshakes idle at varying rates. Every
// result is checked in order against a cycle-free model of the table.
// ----------------------------------------------------------------------------
module retransmit_timeout_table_tb;
    import rtt_pkg::*;

    localparam int ENTRIES          = ENTRIES_DEF;
    localparam int PHASES           = 8;
    localparam int RANDOM_PER_PHASE = 72;
    localparam int DRAIN_CYCLES     = 12;
    localparam int LIMIT_CYCLES     = 400000;
    localparam logic [7:0] TIMEOUT_RST = 8'd3;
    localparam logic [7:0] MAX_RTY_RST = 8'd3;
    localparam int CFG_IDX_LAST     = CFG_KEY0 + KEY_REGS - 1;
    localparam int CFG_IDX_TOP      = (1 << CFG_W) - 1;
    localparam int SEND_IDLE [4]    = '{0, 71, 0, 32};
    localparam int RECV_STALL [4]   = '{0, 0, 71, 32};

    typedef struct packed {
        logic [1:0]       act;
        logic [KEY_W-1:0] key;
        logic [31:0]      now;
    } table_cmd_t;

    typedef struct packed {
        logic [2:0]       ev;
        logic             matched;
        logic [1:0]       entry;
        logic [KEY_W-1:0] key;
        logic [7:0]       retries;
        logic             armed;
        logic             last;
    } outcome_t;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DW-1:0] i_cfg_wdata   = '0;
    logic              i_valid       = 1'b0;
    logic              o_ready;
    logic [1:0]        i_action      = '0;
    logic [KEY_W-1:0]  i_command_key = '0;
    logic [31:0]       i_now_seconds = '0;
    logic              o_valid;
    logic              i_ready       = 1'b0;
    logic [2:0]        o_event_res;
    logic              o_matched;
    logic [1:0]        o_entry_index;
    logic [KEY_W-1:0]  o_entry_key;
    logic [7:0]        o_retry_count;
    logic              o_armed;
    logic              o_last_result;

    retransmit_timeout_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_command_key (i_command_key),
        .i_now_seconds (i_now_seconds),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_event_res   (o_event_res),
        .o_matched     (o_matched),
        .o_entry_index (o_entry_index),
        .o_entry_key   (o_entry_key),
        .o_retry_count (o_retry_count),
        .o_armed       (o_armed),
        .o_last_result (o_last_result)
    );

    // table model, owned by the checking block
    logic [7:0]       cur_timeout;
    logic [7:0]       cur_max_rty;
    logic [KEY_W-1:0] tbl_key     [ENTRIES];
    logic             tbl_armed   [ENTRIES];
    logic [7:0]       tbl_retries [ENTRIES];
    logic [31:0]      tbl_start   [ENTRIES];

    table_cmd_t  pending_q [$];
    outcome_t    expect_q [$];
    table_cmd_t  drv_cmd;
    outcome_t    got;
    outcome_t    want;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          issued_count   = 0;
    int          accepted_count = 0;
    int          results_seen   = 0;
    int          resend_seen    = 0;
    int          exhaust_seen   = 0;
    int          errors         = 0;
    int unsigned cycle_count    = 0;

    // generator view of the table setup
    logic [31:0]      gen_time;
    logic [7:0]       gen_timeout;
    logic [KEY_W-1:0] gen_keys [ENTRIES];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic outcome_t entry_outcome(input logic [2:0] ev, input logic m,
                                               input int idx, input logic last);
        outcome_t r;
        r = '0;
        r.ev      = ev;
        r.matched = m;
        r.last    = last;
        if (idx >= 0) begin
            r.entry   = 2'(idx);
            r.key     = tbl_key[idx];
            r.retries = tbl_retries[idx];
            r.armed   = tbl_armed[idx];
        end
        return r;
    endfunction

    task automatic clear_key_entries(input logic [KEY_W-1:0] key);
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_key[i] == key) begin
                tbl_armed[i]   = 1'b0;
                tbl_retries[i] = '0;
                tbl_start[i]   = '0;
            end
        end
    endtask

    task automatic table_step(input logic [1:0] act, input logic [KEY_W-1:0] key,
                              input logic [31:0] now);
        outcome_t    fired [MAX_OUT];
        int          n;
        int          hit;
        logic [31:0] elapsed;
        logic [2:0]  ev;
        n   = 0;
        hit = -1;
        if (act == ACT_TICK) begin
            for (int i = 0; i < ENTRIES; i++) begin
                elapsed = now - tbl_start[i];
                if (tbl_armed[i] && elapsed >= 32'(cur_timeout)) begin
                    tbl_start[i] = now;
                    if (tbl_retries[i] < cur_max_rty) begin
                        tbl_retries[i] = tbl_retries[i] + 8'd1;
                        ev = EV_RESEND;
                    end else begin
                        clear_key_entries(tbl_key[i]);
                        ev = EV_EXHAUSTED;
                    end
                    if (n < MAX_OUT) begin
                        fired[n] = entry_outcome(ev, 1'b1, i, 1'b0);
                        n++;
                    end
                end
            end
            if (n == 0) begin
                expect_q.push_back(entry_outcome(EV_NONE, 1'b0, -1, 1'b1));
            end else begin
                fired[n-1].last = 1'b1;
                for (int k = 0; k < n; k++) expect_q.push_back(fired[k]);
            end
        end else begin
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (tbl_key[i] == key) hit = i;
            end
            case (act)
                ACT_REGISTER: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (tbl_key[i] == key && !tbl_armed[i]) begin
                            tbl_armed[i]   = 1'b1;
                            tbl_retries[i] = '0;
                            tbl_start[i]   = now;
                        end
                    end
                end
                ACT_ACK: clear_key_entries(key);
                default: ;
            endcase
            expect_q.push_back(entry_outcome(act == ACT_QUERY ? EV_QUERY : EV_DONE,
                                             hit >= 0, hit, 1'b1));
        end
    endtask

    // item driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_cmd = pending_q.pop_front();
                i_valid       <= 1'b1;
                i_action      <= drv_cmd.act;
                i_command_key <= drv_cmd.key;
                i_now_seconds <= drv_cmd.now;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge i_clk) begin
        i_ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor, register mirror and table prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_timeout = TIMEOUT_RST;
            cur_max_rty = MAX_RTY_RST;
            for (int i = 0; i < ENTRIES; i++) begin
                tbl_key[i]     = KEY_W'(i + 1);
                tbl_armed[i]   = 1'b0;
                tbl_retries[i] = '0;
                tbl_start[i]   = '0;
            end
        end else begin
            if (o_valid && i_ready) begin
                got.ev      = o_event_res;
                got.matched = o_matched;
                got.entry   = o_entry_index;
                got.key     = o_entry_key;
                got.retries = o_retry_count;
                got.armed   = o_armed;
                got.last    = o_last_result;
                if (expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: ev %0d matched %0d entry %0d key %h",
                             $time, got.ev, got.matched, got.entry, got.key);
                end else begin
                    want = expect_q.pop_front();
                    results_seen++;
                    if (want.ev == EV_RESEND) resend_seen++;
                    if (want.ev == EV_EXHAUSTED) exhaust_seen++;
                    if (got.ev !== want.ev || got.matched !== want.matched ||
                        got.entry !== want.entry || got.key !== want.key ||
                        got.retries !== want.retries || got.armed !== want.armed ||
                        got.last !== want.last) begin
                        errors++;
                        $display("%0t: expected ev %0d matched %0d entry %0d key %h rty %0d armed %0d last %0d",
                                 $time, want.ev, want.matched, want.entry, want.key,
                                 want.retries, want.armed, want.last);
                        $display("%0t: actual   ev %0d matched %0d entry %0d key %h rty %0d armed %0d last %0d",
                                 $time, got.ev, got.matched, got.entry, got.key,
                                 got.retries, got.armed, got.last);
                    end
                end
            end
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_TIMEOUT) begin
                    cur_timeout = i_cfg_wdata[7:0];
                end else if (i_cfg_index == CFG_MAX_RTY) begin
                    cur_max_rty = i_cfg_wdata[7:0];
                end else if (i_cfg_index >= CFG_KEY0 && i_cfg_index <= CFG_IDX_LAST) begin
                    if (int'(i_cfg_index - CFG_KEY0) < ENTRIES)
                        tbl_key[i_cfg_index - CFG_KEY0] = i_cfg_wdata[KEY_W-1:0];
                end
            end
            if (i_valid && o_ready) begin
                table_step(i_action, i_command_key, i_now_seconds);
                accepted_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: run timed out, %0d items accepted of %0d",
                     $time, accepted_count, issued_count);
            $display("retransmit_timeout_table: mismatch");
            $finish;
        end
    end

    task automatic add_item(input logic [1:0] act, input logic [KEY_W-1:0] key,
                            input logic [31:0] now);
        table_cmd_t c;
        c.act = act;
        c.key = key;
        c.now = now;
        pending_q.push_back(c);
        issued_count++;
    endtask

    task automatic write_reg(input int idx, input logic [CFG_DW-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_W'(idx);
        i_cfg_wdata <= data;
    endtask

    // upper bits of the 8-bit registers get junk; an unused index is written last
    task automatic program_table(input logic [7:0] to, input logic [7:0] max_rty,
                                 input logic [KEY_W-1:0] k0, input logic [KEY_W-1:0] k1,
                                 input logic [KEY_W-1:0] k2);
        write_reg(CFG_TIMEOUT, {8'($urandom), to});
        write_reg(CFG_MAX_RTY, {8'($urandom), max_rty});
        write_reg(CFG_KEY0, k0);
        write_reg(CFG_KEY0 + 1, k1);
        write_reg(CFG_KEY0 + 2, k2);
        write_reg($urandom_range(CFG_IDX_LAST + 1, CFG_IDX_TOP), CFG_DW'($urandom));
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        gen_timeout = to;
        gen_keys[0] = k0;
        gen_keys[1] = k1;
        gen_keys[2] = k2;
    endtask

    task automatic add_random_item();
        logic [1:0]       act;
        logic [KEY_W-1:0] key;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            add_item(2'($urandom), KEY_W'($urandom), $urandom);
        end else begin
            gen_time = gen_time + $urandom_range(0, (gen_timeout >> 1) + 1);
            key = ($urandom_range(0, 99) < 85) ? gen_keys[$urandom_range(0, ENTRIES - 1)]
                                               : KEY_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 40) act = ACT_TICK;
            else if (pick < 70) act = ACT_REGISTER;
            else if (pick < 82) act = ACT_ACK;
            else act = ACT_QUERY;
            add_item(act, key, (act == ACT_TICK || act == ACT_REGISTER) ? gen_time : $urandom);
        end
    endtask

    task automatic wait_drained();
        while (accepted_count != issued_count || expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [KEY_W-1:0] k0;
        logic [KEY_W-1:0] k1;
        gen_timeout = TIMEOUT_RST;
        for (int i = 0; i < ENTRIES; i++) gen_keys[i] = KEY_W'(i + 1);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            send_idle_pct  = SEND_IDLE[p % 4];
            recv_stall_pct = RECV_STALL[p % 4];
            gen_time       = $urandom;
            case (p)
                0: begin
                    // default keys 1, 2, 3 with timeout 3 and three retries
                    add_item(ACT_QUERY, 16'd1, $urandom);
                    add_item(ACT_REGISTER, 16'hFFFF, 32'd50);
                    add_item(ACT_ACK, 16'h0000, $urandom);
                    add_item(ACT_QUERY, 16'hABCD, $urandom);
                    add_item(ACT_TICK, 16'hFFFF, 32'd100);
                    add_item(ACT_REGISTER, 16'd1, 32'd100);
                    add_item(ACT_REGISTER, 16'd1, 32'd101);
                    add_item(ACT_REGISTER, 16'd2, 32'd101);
                    add_item(ACT_TICK, 16'd0, 32'd102);
                    add_item(ACT_TICK, 16'd0, 32'd103);
                    add_item(ACT_REGISTER, 16'd3, 32'd103);
                    add_item(ACT_TICK, 16'd0, 32'd104);
                    add_item(ACT_TICK, 16'd0, 32'd106);
                    add_item(ACT_TICK, 16'd0, 32'd109);
                    add_item(ACT_TICK, 16'd0, 32'd112);
                    add_item(ACT_QUERY, 16'd1, $urandom);
                    add_item(ACT_ACK, 16'd2, $urandom);
                    add_item(ACT_QUERY, 16'd3, $urandom);
                    add_item(ACT_TICK, 16'd0, 32'd115);
                    // elapsed time across the wrap of the seconds counter
                    add_item(ACT_REGISTER, 16'd1, 32'hFFFF_FFFE);
                    add_item(ACT_TICK, 16'd0, 32'd0);
                    add_item(ACT_TICK, 16'd0, 32'd1);
                    add_item(ACT_ACK, 16'd1, 32'hFFFF_FFFF);
                    add_item(ACT_QUERY, 16'd1, 32'd0);
                end
                1: program_table(8'd0, 8'd0, 16'h0000, 16'hFFFF, 16'h0000);
                2: program_table(8'd255, 8'd255, KEY_W'($urandom), KEY_W'($urandom),
                                 KEY_W'($urandom));
                3: program_table(8'd1, 8'd1, 16'd7, 16'd7, 16'd7);
                default: begin
                    k0 = KEY_W'($urandom);
                    k1 = $urandom_range(0, 1) ? k0 : KEY_W'($urandom);
                    program_table(8'($urandom_range(0, 6)), 8'($urandom_range(0, 4)), k0, k1,
                                  $urandom_range(0, 1) ? k1 : KEY_W'($urandom));
                end
            endcase
            if (p != 0) repeat (RANDOM_PER_PHASE) add_random_item();
            wait_drained();
        end
        $display("covered %0d items over %0d table settings and four handshake idle mixes",
                 accepted_count, PHASES);
        $display("checked %0d results, %0d resend requests and %0d exhaustions among them",
                 results_seen, resend_seen, exhaust_seen);
        if (expect_q.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, expect_q.size());
        if (errors == 0 && expect_q.size() == 0) begin
            $display("retransmit_timeout_table: match");
        end else begin
            $display("retransmit_timeout_table: mismatch");
        end
        $finish;
    end

endmodule

// ===== retransmit_timeout_table.f =====
sv/rtt_pkg.sv
sv/retransmit_timeout_table.sv
dv/retransmit_timeout_table_tb.sv
